/* sv/binom_pkg.sv */
// binom_pkg: shared types for the binomial coefficient block
// used by binom_core and binomial_coefficient; no dependencies
`default_nettype none
package binom_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_ITER, ST_GCD, ST_DIV1, ST_DIV2, ST_DIV3, ST_CHK, ST_MUL, ST_DONE
  } state_e;
  typedef struct packed {
    logic [63:0] count;
    logic        overflow;
  } result_t;
endpackage
`default_nettype wire

/* sv/binom_core.sv */
// binom_core: sequencer around one shared 64-bit restoring divider
// depends on binom_pkg
`default_nettype none
module binom_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               func_i,
  input  wire logic [31:0]        set_size_i,
  input  wire logic [31:0]        pick_count_i,
  output logic                    busy_o,
  output logic                    done_o,
  output binom_pkg::result_t      res_o
);
  binom_pkg::state_e state_q, state_d;
  logic [31:0] m_q, m_d, k_q, k_d, i_q, i_d;
  logic [63:0] acc_q, acc_d, num_q, num_d, den_q, den_d, ga_q, ga_d, gb_q, gb_d;
  logic [63:0] dvd_q, dvd_d, dvs_q, dvs_d, quo_q, quo_d, rem_q, rem_d;
  logic [63:0] plo_q, plo_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        div_run_q, div_run_d;
  logic [1:0]  dsel_q, dsel_d;
  logic        ovf_q, ovf_d;
  logic [64:0] rtry;
  logic [31:0] mul_a;
  logic [63:0] prod64;
  logic [32:0] hsum;
  logic [31:0] mm;

  // one bit of restoring division per cycle
  assign rtry = {rem_q, dvd_q[63]} - {1'b0, dvs_q};
  // num stays below 2^32, so acc * num is two 32x32 products on one multiplier
  assign mul_a = (state_q == binom_pkg::ST_MUL) ? acc_q[63:32] : acc_q[31:0];
  assign prod64 = {32'd0, mul_a} * {32'd0, num_q[31:0]};
  assign hsum = {1'b0, prod64[31:0]} + {1'b0, plo_q[63:32]};
  assign mm = func_i ? set_size_i + pick_count_i - 32'd1 : set_size_i;

  always_comb begin
    state_d = state_q; m_d = m_q; k_d = k_q; i_d = i_q; acc_d = acc_q;
    num_d = num_q; den_d = den_q; ga_d = ga_q; gb_d = gb_q;
    dvd_d = dvd_q; dvs_d = dvs_q; quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    div_run_d = div_run_q; dsel_d = dsel_q; ovf_d = ovf_q; plo_d = plo_q;
    if (div_run_q) begin
      dvd_d = {dvd_q[62:0], 1'b0};
      if (!rtry[64]) begin
        rem_d = rtry[63:0]; quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], dvd_q[63]}; quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) div_run_d = 1'b0;
    end else begin
      case (state_q)
        binom_pkg::ST_IDLE: begin
          if (start_i) begin
            m_d = mm; k_d = pick_count_i; acc_d = 64'd1; ovf_d = 1'b0;
            i_d = 32'd1; state_d = binom_pkg::ST_SETUP;
          end
        end
        binom_pkg::ST_SETUP: begin
          if (k_q > m_q) begin
            acc_d = 64'd0; state_d = binom_pkg::ST_DONE;
          end else begin
            if (k_q > m_q - k_q) k_d = m_q - k_q;
            state_d = binom_pkg::ST_ITER;
          end
        end
        binom_pkg::ST_ITER: begin
          if (i_q > k_q || k_q == 32'd0) state_d = binom_pkg::ST_DONE;
          else begin
            num_d = {32'd0, m_q - k_q} + {32'd0, i_q};
            den_d = {32'd0, i_q};
            ga_d = {32'd0, m_q - k_q} + {32'd0, i_q};
            gb_d = {32'd0, i_q};
            state_d = binom_pkg::ST_GCD;
          end
        end
        binom_pkg::ST_GCD: begin
          if (dsel_q == 2'd1) begin
            ga_d = gb_q; gb_d = rem_q; dsel_d = 2'd0;
          end else if (gb_q == 64'd0) begin
            dvd_d = num_q; dvs_d = ga_q; rem_d = '0; quo_d = '0;
            cnt_d = 7'd64; div_run_d = 1'b1; state_d = binom_pkg::ST_DIV1;
          end else begin
            dvd_d = ga_q; dvs_d = gb_q; rem_d = '0; quo_d = '0;
            cnt_d = 7'd64; div_run_d = 1'b1; dsel_d = 2'd1;
          end
        end
        binom_pkg::ST_DIV1: begin
          num_d = quo_q;
          dvd_d = den_q; dvs_d = ga_q; rem_d = '0; quo_d = '0;
          cnt_d = 7'd64; div_run_d = 1'b1; state_d = binom_pkg::ST_DIV2;
        end
        binom_pkg::ST_DIV2: begin
          dvd_d = acc_q; dvs_d = quo_q; rem_d = '0; quo_d = '0;
          cnt_d = 7'd64; div_run_d = 1'b1; state_d = binom_pkg::ST_DIV3;
        end
        binom_pkg::ST_DIV3: begin
          acc_d = quo_q; state_d = binom_pkg::ST_CHK;
        end
        binom_pkg::ST_CHK: begin
          plo_d = prod64; state_d = binom_pkg::ST_MUL;
        end
        binom_pkg::ST_MUL: begin
          if (prod64[63:32] != 32'd0 || hsum[32]) begin
            ovf_d = 1'b1; acc_d = 64'd0; state_d = binom_pkg::ST_DONE;
          end else begin
            acc_d = {hsum[31:0], plo_q[31:0]};
            if (i_q == 32'hFFFF_FFFF) state_d = binom_pkg::ST_DONE;
            else begin
              i_d = i_q + 32'd1; state_d = binom_pkg::ST_ITER;
            end
          end
        end
        binom_pkg::ST_DONE: state_d = binom_pkg::ST_IDLE;
        default: state_d = binom_pkg::ST_IDLE;
      endcase
    end
  end

  always_comb begin
    busy_o = (state_q != binom_pkg::ST_IDLE);
    done_o = (state_q == binom_pkg::ST_DONE) && !div_run_q;
    res_o.count = acc_q;
    res_o.overflow = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= binom_pkg::ST_IDLE; div_run_q <= 1'b0; dsel_q <= 2'd0; cnt_q <= '0;
    end else begin
      state_q <= state_d; div_run_q <= div_run_d; dsel_q <= dsel_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; k_q <= k_d; i_q <= i_d; acc_q <= acc_d; num_q <= num_d; den_q <= den_d;
    ga_q <= ga_d; gb_q <= gb_d; dvd_q <= dvd_d; dvs_q <= dvs_d; quo_q <= quo_d;
    rem_q <= rem_d; ovf_q <= ovf_d; plo_q <= plo_d;
  end
endmodule
`default_nettype wire

/* sv/binomial_coefficient.sv */
// binomial_coefficient: top level with input handshake and output register
// depends on binom_pkg and binom_core
`default_nettype none
// Usage: a request (func_i, set_size_i, pick_count_i) transfers when
// in_valid_i is high and in_stall_o low. func_i = 1 asks for combinations
// with repetition, C(m+n-1, n), with m+n-1 wrapping at 32 bits.
// One result (count_o, overflow_o) is offered on out_valid_o and transfers
// when out_stall_i is low. overflow_o flags a product beyond 64 bits, with
// count_o = 0 in that case; n > m gives count_o = 0 without overflow.
// When n > m, setup leads straight to the result. Else each loop step runs
// the Euclid remainder steps, each a divide in the single shared bit-serial
// divider; three more divides follow, then a product in two halves on one
// 32x32 multiplier. At most 34 loop steps run before the result completes
// or overflows.
// One request at a time: in_stall_o stays high while a request is in work
// or while its result waits in the output register.
// A stalled result holds its value. Reset clears the sequencer and the
// output valid; no request is in work after reset.
module binomial_coefficient (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [31:0] set_size_i,
  input  wire logic [31:0] pick_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      count_o,
  output logic             overflow_o
);
  logic busy, done, start;
  binom_pkg::result_t res, res_q;
  logic vld_q;

  assign in_stall_o = busy || vld_q;
  assign start = in_valid_i && !in_stall_o;

  binom_core u_core (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .func_i(func_i),
    .set_size_i(set_size_i), .pick_count_i(pick_count_i),
    .busy_o(busy), .done_o(done), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (done) vld_q <= 1'b1;
    else if (!out_stall_i) vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (done) res_q <= res;
  end

  assign out_valid_o = vld_q;
  assign count_o = res_q.count;
  assign overflow_o = res_q.overflow;
endmodule
`default_nettype wire

/* bench/binomial_coefficient_checker.sv */
// binomial_coefficient_checker: watches both channels, predicts each result and compares
// depends on binom_pkg for the result type
`default_nettype none
module binomial_coefficient_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic        func_i,
  input  wire logic [31:0] set_size_i,
  input  wire logic [31:0] pick_count_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [63:0] count_i,
  input  wire logic        overflow_i,
  output int               errors_o,
  output int               pending_o
);
  binom_pkg::result_t coeff_q[$];

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic binom_pkg::result_t predict_coeff(logic sel, logic [31:0] m,
                                                       logic [31:0] n);
    binom_pkg::result_t res;
    longint unsigned acc, num, den, g;
    logic [31:0] k, i;
    acc = 1;
    res.count = '0;
    res.overflow = 1'b0;
    // repetition form wraps m+n-1 at 32 bits
    if (sel) m = m + n - 32'd1;
    if (n > m) return res;
    k = n;
    if (k > m - k) k = m - k;
    for (i = 1; i <= k; i++) begin
      num = {32'd0, m - k} + {32'd0, i};
      den = {32'd0, i};
      g = euclid_gcd(num, den);
      num = num / g;
      den = den / g;
      acc = acc / den;
      if (acc > 64'hFFFF_FFFF_FFFF_FFFF / num) begin
        res.overflow = 1'b1;
        return res;
      end
      acc = acc * num;
      if (i == 32'hFFFF_FFFF) break;
    end
    res.count = acc;
    return res;
  endfunction

  assign pending_o = coeff_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    binom_pkg::result_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      errors_o <= 0;
      coeff_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        coeff_q.push_back(predict_coeff(func_i, set_size_i, pick_count_i));
      if (out_valid_i && !out_stall_i) begin
        if (coeff_q.size() == 0) begin
          $error("result transfer with nothing expected: count %0d overflow %0d",
                 count_i, overflow_i);
          errs++;
        end else begin
          want = coeff_q.pop_front();
          if (count_i !== want.count) begin
            $error("count: expected %0d actual %0d", want.count, count_i);
            errs++;
          end
          if (overflow_i !== want.overflow) begin
            $error("overflow: expected %0d actual %0d", want.overflow, overflow_i);
            errs++;
          end
        end
      end
      errors_o <= errors_o + errs;
    end
  end
endmodule
`default_nettype wire

/* bench/tb_binomial_coefficient.sv */
// tb_binomial_coefficient: drives requests and stalls into binomial_coefficient
// depends on binom_pkg, binomial_coefficient and binomial_coefficient_checker
`default_nettype none
module tb_binomial_coefficient;
  localparam int IDLE_LIMIT = 600000;
  localparam int RANDOM_REQS = 217;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [31:0] set_size_i = '0;
  logic [31:0] pick_count_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [63:0] count_o;
  logic        overflow_o;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  bit          stim_done = 1'b0;

  always #4 clk_i = ~clk_i;

  binomial_coefficient dut (.*);

  binomial_coefficient_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .func_i, .set_size_i,
    .pick_count_i, .out_valid_i(out_valid_o), .out_stall_i, .count_i(count_o),
    .overflow_i(overflow_o), .errors_o(errors), .pending_o(pending)
  );

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  // hold the request until a transfer, then maybe drop valid for a gap
  task automatic send_request(logic sel, logic [31:0] m, logic [31:0] n);
    bit stalled;
    int gap;
    in_valid_i   <= 1'b1;
    func_i       <= sel;
    set_size_i   <= m;
    pick_count_i <= n;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // receiver: random stalls, one long hold-off early on
  initial begin
    int gap;
    int round;
    round = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      round++;
      if (round == 5) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
      end
      gap = stim_done ? 0 : pick_gap();
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL binomial_coefficient");
      $finish;
    end
  end

  initial begin
    int kind;
    logic [31:0] m, n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_request(1'b0, 32'd5, 32'd7);            // pick exceeds set
    send_request(1'b0, 32'd0, 32'd0);            // zero pick of empty set
    send_request(1'b0, 32'd9, 32'd0);
    send_request(1'b0, 32'd10, 32'd10);
    send_request(1'b0, 32'd10, 32'd3);
    send_request(1'b0, 32'd52, 32'd5);
    send_request(1'b0, 32'd67, 32'd33);          // largest that fits near the middle
    send_request(1'b0, 32'd68, 32'd34);          // just overflows
    send_request(1'b0, 32'd100, 32'd50);
    send_request(1'b0, 32'hFFFF_FFFF, 32'd1);
    send_request(1'b0, 32'hFFFF_FFFF, 32'd2);
    send_request(1'b0, 32'hFFFF_FFFF, 32'd3);    // product too wide
    send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_request(1'b0, 32'd0, 32'hFFFF_FFFF);
    send_request(1'b1, 32'd0, 32'd0);            // repetition wraps to 2^32-1
    send_request(1'b1, 32'd0, 32'd5);
    send_request(1'b1, 32'd1, 32'd0);
    send_request(1'b1, 32'd3, 32'd4);
    send_request(1'b1, 32'd20, 32'd20);
    send_request(1'b1, 32'hFFFF_FFFF, 32'd1);    // wraps around
    send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b1, 32'd2, 32'hFFFF_FFFF);

    for (int r = 0; r < RANDOM_REQS; r++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        m = $urandom_range(0, 72);
        n = $urandom_range(0, 40);
      end else if (kind < 8) begin
        m = $urandom;
        n = $urandom_range(0, 4);
        if ($urandom_range(0, 1)) n = m - n;
      end else begin
        m = $urandom;
        n = $urandom;
      end
      send_request(1'(($urandom_range(0, 2)) == 0), m, n);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;

    // let the checker see the last input transfer before polling
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0)
      $display("PASS binomial_coefficient");
    else
      $display("FAIL binomial_coefficient");
    $finish;
  end
endmodule
`default_nettype wire
